[rtl/r2fft_pkg.sv]
// Shared types and constants for the radix-2 FFT block.
// Used by r2fft_ctrl, r2fft_dp and radix2_complex_fft_top; depends on nothing.
`default_nettype none

package r2fft_pkg;

    // Fixed field widths of the command and configuration ports
    localparam int POS_W      = 10;
    localparam int OPC_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int LOG2_W     = 4;
    localparam int SHIFT_W    = 5;

    localparam logic [LOG2_W-1:0]    LOG2_SIZE_RST    = 4'd10;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 2'd1;

    localparam real PI = 3.14159265358979323846;

    typedef enum logic [OPC_W-1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // Source of the memory write data
    typedef enum logic [2:0] {
        WR_ZERO   = 3'd0,
        WR_SAMPLE = 3'd1,
        WR_RDATA  = 3'd2,
        WR_UREG   = 3'd3,
        WR_SUM    = 3'd4,
        WR_DIFF   = 3'd5,
        WR_SCALED = 3'd6
    } t_wr_src;

    // Operand pair of the shared multiplier
    typedef enum logic [1:0] {
        MUL_VR_CR = 2'd0,
        MUL_VI_CI = 2'd1,
        MUL_VI_CR = 2'd2,
        MUL_VR_CI = 2'd3
    } t_mul_sel;

    // Accumulator operation on the registered product
    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_LOAD_R = 3'd1,
        ACC_SUB_R  = 3'd2,
        ACC_LOAD_I = 3'd3,
        ACC_ADD_I  = 3'd4
    } t_acc_op;

    // Command bundle from controller to datapath
    typedef struct packed {
        logic               wr_en;
        t_wr_src            wr_src;
        logic               cap_v;
        logic               cap_u;
        t_mul_sel           mul_sel;
        t_acc_op            acc_op;
        logic               round_en;
        logic               inverse;
        logic [SHIFT_W-1:0] shift;
        logic               rd_zero;
    } t_dp_cmd;

endpackage

`default_nettype wire

[rtl/r2fft_dp.sv]
// Datapath of the radix-2 FFT: sample memory, twiddle ROM, shared multiplier,
// rounding, saturation and write-data selection. Depends on r2fft_pkg.
`default_nettype none

module r2fft_dp
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int DATA_WIDTH    = 48,
    parameter int TWIDDLE_WIDTH = 18
) (
    input  wire logic                              i_clk,
    input  wire t_dp_cmd                           i_cmd,
    input  wire logic [$clog2(MAX_POINTS)-1:0]     i_rd_addr,
    input  wire logic [$clog2(MAX_POINTS)-1:0]     i_wr_addr,
    input  wire logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] i_tw_addr,
    input  wire logic signed [DATA_WIDTH-1:0]      i_sample_real,
    input  wire logic signed [DATA_WIDTH-1:0]      i_sample_imag,
    output logic signed [DATA_WIDTH-1:0]           o_bin_real,
    output logic signed [DATA_WIDTH-1:0]           o_bin_imag
);

    localparam int LOG_MAX   = $clog2(MAX_POINTS);
    localparam int ROM_AW    = (LOG_MAX > 1) ? LOG_MAX - 1 : 1;
    localparam int ROM_DEPTH = 1 << ROM_AW;
    localparam int FRAC      = TWIDDLE_WIDTH - 1;
    localparam int PW        = DATA_WIDTH + TWIDDLE_WIDTH;
    localparam int AW        = PW + 1;
    localparam int MW        = 2 * DATA_WIDTH;

    typedef logic signed [TWIDDLE_WIDTH-1:0] t_rom [ROM_DEPTH];

    // Twiddle magnitudes rounded half up and clipped below one, sign restored
    function automatic t_rom build_rom(input bit want_sin);
        t_rom rom;
        real  ang;
        real  v;
        real  mag;
        real  rv;
        int   q;
        for (int m = 0; m < ROM_DEPTH; m++) begin
            ang = 2.0 * PI * m / MAX_POINTS;
            v   = want_sin ? $sin(ang) : $cos(ang);
            mag = (v < 0.0) ? -v : v;
            rv  = $floor(mag * (2.0 ** FRAC) + 0.5);
            if (rv > (2.0 ** FRAC) - 1.0) begin
                rv = (2.0 ** FRAC) - 1.0;
            end
            q = $rtoi(rv);
            if (v < 0.0) begin
                q = -q;
            end
            rom[m] = TWIDDLE_WIDTH'(q);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_rom(1'b0);
    localparam t_rom SIN_ROM = build_rom(1'b1);

    // Saturate a wide signed value to the data range
    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [AW-1:0] x);
        logic signed [DATA_WIDTH-1:0] res;
        if ((&x[AW-1:DATA_WIDTH-1]) || !(|x[AW-1:DATA_WIDTH-1])) begin
            res = x[DATA_WIDTH-1:0];
        end else if (x[AW-1]) begin
            res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // Round to nearest by FRAC bits, then saturate
    function automatic logic signed [DATA_WIDTH-1:0] finish(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] t;
        t = acc + (AW'(1) <<< (FRAC - 1));
        return sat_dw(t >>> FRAC);
    endfunction

    logic [MW-1:0] mem [MAX_POINTS];
    logic [MW-1:0] r_rd_data;
    logic signed [TWIDDLE_WIDTH-1:0] r_tw_c;
    logic signed [TWIDDLE_WIDTH-1:0] r_tw_s;
    logic signed [DATA_WIDTH-1:0] r_vr, r_vi, r_ur, r_ui, r_tr, r_ti;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc_r, r_acc_i;

    logic signed [DATA_WIDTH-1:0]    rd_re, rd_im;
    logic signed [DATA_WIDTH-1:0]    mul_a;
    logic signed [TWIDDLE_WIDTH-1:0] mul_b;
    logic signed [PW-1:0]            prod;
    logic [MW-1:0]                   wr_data;

    assign rd_re = r_rd_data[DATA_WIDTH-1:0];
    assign rd_im = r_rd_data[MW-1:DATA_WIDTH];

    // Sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // Twiddle ROM with registered output, sine negated for the inverse direction
    always_ff @(posedge i_clk) begin
        r_tw_c <= COS_ROM[i_tw_addr];
        r_tw_s <= i_cmd.inverse ? -SIN_ROM[i_tw_addr] : SIN_ROM[i_tw_addr];
    end

    // Select multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_VR_CR: begin mul_a = r_vr; mul_b = r_tw_c; end
            MUL_VI_CI: begin mul_a = r_vi; mul_b = r_tw_s; end
            MUL_VI_CR: begin mul_a = r_vi; mul_b = r_tw_c; end
            MUL_VR_CI: begin mul_a = r_vr; mul_b = r_tw_s; end
            default:   begin mul_a = r_vr; mul_b = r_tw_c; end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // Capture operands, product, accumulators and rounded twiddle product
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (i_cmd.cap_v) begin
            r_vr <= rd_re;
            r_vi <= rd_im;
        end
        if (i_cmd.cap_u) begin
            r_ur <= rd_re;
            r_ui <= rd_im;
        end
        case (i_cmd.acc_op)
            ACC_LOAD_R: r_acc_r <= AW'(r_prod);
            ACC_SUB_R:  r_acc_r <= r_acc_r - AW'(r_prod);
            ACC_LOAD_I: r_acc_i <= AW'(r_prod);
            ACC_ADD_I:  r_acc_i <= r_acc_i + AW'(r_prod);
            default: ;
        endcase
        if (i_cmd.round_en) begin
            r_tr <= finish(r_acc_r);
            r_ti <= finish(r_acc_i);
        end
    end

    // Select memory write data
    always_comb begin
        case (i_cmd.wr_src)
            WR_ZERO:   wr_data = '0;
            WR_SAMPLE: wr_data = {i_sample_imag, i_sample_real};
            WR_RDATA:  wr_data = r_rd_data;
            WR_UREG:   wr_data = {r_ui, r_ur};
            WR_SUM:    wr_data = {sat_dw(AW'(r_ui) + AW'(r_ti)), sat_dw(AW'(r_ur) + AW'(r_tr))};
            WR_DIFF:   wr_data = {sat_dw(AW'(r_ui) - AW'(r_ti)), sat_dw(AW'(r_ur) - AW'(r_tr))};
            WR_SCALED: wr_data = {rd_im >>> i_cmd.shift, rd_re >>> i_cmd.shift};
            default:   wr_data = '0;
        endcase
    end

    // Drive bin outputs, zero for an out-of-range read
    assign o_bin_real = i_cmd.rd_zero ? '0 : rd_re;
    assign o_bin_imag = i_cmd.rd_zero ? '0 : rd_im;

endmodule

`default_nettype wire

[rtl/r2fft_ctrl.sv]
// Controller of the radix-2 FFT: command decode, configuration registers,
// clear sweep, permutation, butterfly and scaling sequencing. Depends on r2fft_pkg.
`default_nettype none

module r2fft_ctrl
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [OPC_W-1:0]              i_opcode,
    input  wire logic [POS_W-1:0]              i_position,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic                               o_bin_valid,
    output logic                               o_out_of_range,
    output t_dp_cmd                            o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]      o_rd_addr,
    output logic [$clog2(MAX_POINTS)-1:0]      o_wr_addr,
    output logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] o_tw_addr
);

    localparam int LOG_MAX = $clog2(MAX_POINTS);
    localparam int ADDR_W  = LOG_MAX;
    localparam int ROM_AW  = (LOG_MAX > 1) ? LOG_MAX - 1 : 1;
    localparam int CNT_W   = ADDR_W + 1;
    localparam int EXT_W   = (ADDR_W > POS_W) ? ADDR_W : POS_W;
    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(MAX_POINTS - 1);

    typedef enum logic [17:0] {
        ST_CLEAR = 18'h00001,
        ST_IDLE  = 18'h00002,
        ST_PRD_A = 18'h00004,
        ST_PRD_B = 18'h00008,
        ST_PWR_A = 18'h00010,
        ST_PWR_B = 18'h00020,
        ST_BRD_V = 18'h00040,
        ST_BRD_U = 18'h00080,
        ST_BM0   = 18'h00100,
        ST_BM1   = 18'h00200,
        ST_BM2   = 18'h00400,
        ST_BM3   = 18'h00800,
        ST_BFIN  = 18'h01000,
        ST_BRND  = 18'h02000,
        ST_BWR_U = 18'h04000,
        ST_BWR_V = 18'h08000,
        ST_SRD   = 18'h10000,
        ST_SWR   = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [SHIFT_W-1:0] r_stage, n_stage;
    logic [ADDR_W-1:0]  r_j, n_j;
    logic [ADDR_W-1:0]  r_k, n_k;
    logic               r_rd_pend, n_rd_pend;
    logic               r_oor, n_oor;
    logic [LOG2_W-1:0]  r_log2_size;
    logic               r_inverse;

    logic [SHIFT_W-1:0] lg;
    logic [CNT_W-1:0]   n_pts;
    logic [ADDR_W-1:0]  last_idx;
    logic               accept;
    logic [EXT_W-1:0]   pos_ext;
    logic [ADDR_W-1:0]  pos_addr;
    logic               in_range;
    logic [ADDR_W-1:0]  rev_full, rev;
    logic [CNT_W-1:0]   half, span, k_next;
    logic [ADDR_W-1:0]  bf_u, bf_v, tw_full;
    logic               k_done, j_done, stage_done;

    // Effective transform length, clamped to the supported range
    always_comb begin
        if (r_log2_size == '0) begin
            lg = SHIFT_W'(1);
        end else if (SHIFT_W'(r_log2_size) > SHIFT_W'(LOG_MAX)) begin
            lg = SHIFT_W'(LOG_MAX);
        end else begin
            lg = SHIFT_W'(r_log2_size);
        end
    end

    assign n_pts    = CNT_W'(1) << lg;
    assign last_idx = ADDR_W'(n_pts - CNT_W'(1));
    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign pos_ext  = EXT_W'(i_position);
    assign pos_addr = pos_ext[ADDR_W-1:0];
    assign in_range = ({1'b0, pos_ext} < (EXT_W + 1)'(n_pts));

    // Bit-reversed index over lg bits
    always_comb begin
        for (int b = 0; b < ADDR_W; b++) begin
            rev_full[b] = r_idx[ADDR_W-1-b];
        end
    end
    assign rev = rev_full >> (SHIFT_W'(ADDR_W) - lg);

    // Butterfly addressing and loop bounds
    assign half       = CNT_W'(1) << (r_stage - SHIFT_W'(1));
    assign span       = CNT_W'(1) << r_stage;
    assign bf_u       = r_k + r_j;
    assign bf_v       = bf_u + ADDR_W'(half);
    assign k_next     = {1'b0, r_k} + span;
    assign k_done     = (k_next == n_pts);
    assign j_done     = ({1'b0, r_j} + CNT_W'(1) == half);
    assign stage_done = (r_stage == lg);
    assign tw_full    = r_j << (SHIFT_W'(LOG_MAX) - r_stage);
    assign o_tw_addr  = tw_full[ROM_AW-1:0];

    assign o_cfg_ready    = !busy;
    assign o_bin_valid    = r_rd_pend;
    assign o_out_of_range = r_oor;

    // Sequence the commands and the next state
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_stage   = r_stage;
        n_j       = r_j;
        n_k       = r_k;
        n_rd_pend = 1'b0;
        n_oor     = r_oor;
        o_rd_addr = pos_addr;
        o_wr_addr = pos_addr;
        o_cmd          = '0;
        o_cmd.wr_src   = WR_ZERO;
        o_cmd.mul_sel  = MUL_VR_CR;
        o_cmd.acc_op   = ACC_NONE;
        o_cmd.inverse  = r_inverse;
        o_cmd.shift    = lg;
        o_cmd.rd_zero  = r_oor;

        case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = r_idx;
                n_idx       = r_idx + ADDR_W'(1);
                if (r_idx == LAST_ENTRY) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_WRITE: begin
                            o_cmd.wr_en  = in_range;
                            o_cmd.wr_src = WR_SAMPLE;
                        end
                        OP_RUN: begin
                            n_idx   = '0;
                            n_state = ST_PRD_A;
                        end
                        OP_READ: begin
                            n_rd_pend = 1'b1;
                            n_oor     = !in_range;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PRD_A, ST_PWR_B: begin
                if (r_state == ST_PWR_B) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_src = WR_UREG;
                    o_wr_addr    = rev;
                end
                o_rd_addr = r_idx;
                if (r_state == ST_PRD_A && r_idx < rev) begin
                    n_state = ST_PRD_B;
                end else if (r_idx == last_idx) begin
                    n_stage = SHIFT_W'(1);
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_BRD_V;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = ST_PRD_A;
                end
            end
            ST_PRD_B: begin
                o_rd_addr   = rev;
                o_cmd.cap_u = 1'b1;
                n_state     = ST_PWR_A;
            end
            ST_PWR_A: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_RDATA;
                o_wr_addr    = r_idx;
                n_state      = ST_PWR_B;
            end
            ST_BRD_V: begin
                o_rd_addr = bf_v;
                n_state   = ST_BRD_U;
            end
            ST_BRD_U: begin
                o_rd_addr   = bf_u;
                o_cmd.cap_v = 1'b1;
                n_state     = ST_BM0;
            end
            ST_BM0: begin
                o_cmd.cap_u   = 1'b1;
                o_cmd.mul_sel = MUL_VR_CR;
                n_state       = ST_BM1;
            end
            ST_BM1: begin
                o_cmd.mul_sel = MUL_VI_CI;
                o_cmd.acc_op  = ACC_LOAD_R;
                n_state       = ST_BM2;
            end
            ST_BM2: begin
                o_cmd.mul_sel = MUL_VI_CR;
                o_cmd.acc_op  = ACC_SUB_R;
                n_state       = ST_BM3;
            end
            ST_BM3: begin
                o_cmd.mul_sel = MUL_VR_CI;
                o_cmd.acc_op  = ACC_LOAD_I;
                n_state       = ST_BFIN;
            end
            ST_BFIN: begin
                o_cmd.acc_op = ACC_ADD_I;
                n_state      = ST_BRND;
            end
            ST_BRND: begin
                o_cmd.round_en = 1'b1;
                n_state        = ST_BWR_U;
            end
            ST_BWR_U: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_SUM;
                o_wr_addr    = bf_u;
                n_state      = ST_BWR_V;
            end
            ST_BWR_V: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_DIFF;
                o_wr_addr    = bf_v;
                n_state      = ST_BRD_V;
                // Advance k, then j, then the stage
                if (!k_done) begin
                    n_k = k_next[ADDR_W-1:0];
                end else begin
                    n_k = '0;
                    if (!j_done) begin
                        n_j = r_j + ADDR_W'(1);
                    end else begin
                        n_j = '0;
                        if (!stage_done) begin
                            n_stage = r_stage + SHIFT_W'(1);
                        end else if (r_inverse) begin
                            n_idx   = '0;
                            n_state = ST_SRD;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_SRD: begin
                o_rd_addr = r_idx;
                n_state   = ST_SWR;
            end
            ST_SWR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_SCALED;
                o_wr_addr    = r_idx;
                if (r_idx == last_idx) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = ST_SRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_stage     <= SHIFT_W'(1);
            r_j         <= '0;
            r_k         <= '0;
            r_rd_pend   <= 1'b0;
            r_oor       <= 1'b0;
            r_log2_size <= LOG2_SIZE_RST;
            r_inverse   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_stage   <= n_stage;
            r_j       <= n_j;
            r_k       <= n_k;
            r_rd_pend <= n_rd_pend;
            r_oor     <= n_oor;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LOG2_SIZE) begin
                    r_log2_size <= i_cfg_data;
                end else if (i_cfg_index == CFG_INVERSE_MODE) begin
                    r_inverse <= i_cfg_data[0];
                end
            end
        end
    end

    // A result beat only follows an accepted read
    a_bin_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bin_valid |-> $past(start && !busy && i_opcode == OP_READ))
        else $error("bin beat without a read command");

    // A run command makes the block busy in the next cycle
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_RUN) |=> busy)
        else $error("run command did not start the sequence");

    // No memory write while idle except for an accepted write command
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && o_cmd.wr_en) |-> (start && i_opcode == OP_WRITE))
        else $error("unexpected memory write while idle");

    // Butterfly pair addresses stay ordered and inside the transform
    a_bf_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BRD_V) |-> (bf_u < bf_v && {1'b0, bf_v} < n_pts))
        else $error("butterfly addresses out of order");

endmodule

`default_nettype wire

[rtl/radix2_complex_fft_top.sv]
// Top level of the in-place radix-2 decimation-in-time complex FFT.
// Instantiates r2fft_ctrl and r2fft_dp; depends on r2fft_pkg.
//
// Channel   | Handshake                  | Payload
// ----------+----------------------------+----------------------------------------
// command   | start, busy                | i_opcode, i_position, i_sample_*
// config    | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
// result    | o_bin_valid (strobe)       | o_bin_real, o_bin_imag, o_out_of_range
//
// A read shows its bin in the cycle after acceptance, on a one-cycle strobe
// that the receiver cannot stall. A run performs a bit-reversal permutation
// over one memory port, then (n/2)*log2(n) butterflies (one shared multiplier,
// four products each), then a scaling pass in inverse mode. After reset busy
// stays high while the memory is cleared; configuration writes wait while busy
// is high.
`default_nettype none

module radix2_complex_fft_top
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int DATA_WIDTH    = 48,
    parameter int TWIDDLE_WIDTH = 18
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [OPC_W-1:0]              i_opcode,
    input  wire logic [POS_W-1:0]              i_position,
    input  wire logic signed [DATA_WIDTH-1:0]  i_sample_real,
    input  wire logic signed [DATA_WIDTH-1:0]  i_sample_imag,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic                               o_bin_valid,
    output logic signed [DATA_WIDTH-1:0]       o_bin_real,
    output logic signed [DATA_WIDTH-1:0]       o_bin_imag,
    output logic                               o_out_of_range
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int ROM_AW = (ADDR_W > 1) ? ADDR_W - 1 : 1;

    t_dp_cmd            cmd;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ROM_AW-1:0]  tw_addr;

    r2fft_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_position     (i_position),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_bin_valid    (o_bin_valid),
        .o_out_of_range (o_out_of_range),
        .o_cmd          (cmd),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_tw_addr      (tw_addr)
    );

    r2fft_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .DATA_WIDTH    (DATA_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_tw_addr     (tw_addr),
        .i_sample_real (i_sample_real),
        .i_sample_imag (i_sample_imag),
        .o_bin_real    (o_bin_real),
        .o_bin_imag    (o_bin_imag)
    );

endmodule

`default_nettype wire
